FILE: rtl/dtc_pkg.sv
package dtc_pkg;

    // Stage registers from an accepted word to the result of either conversion path
    localparam int DTC_LAT = 6;

    localparam logic FUNC_TO_SECS   = 1'b0;
    localparam logic FUNC_FROM_SECS = 1'b1;

    typedef struct packed {
        logic        func;
        logic [13:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [4:0]  in_hour;
        logic [5:0]  in_minute;
        logic [5:0]  in_second;
        logic [31:0] in_count;
    } t_in_word;

    typedef struct packed {
        logic [11:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
        logic [31:0] out_count;
        logic        error_flag;
    } t_out_word;

    // Days in the year before the first of a January-based month
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // Length of a month in a common year
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] v;
        case (m)
            4'd2:    v = 5'd28;
            4'd4:    v = 5'd30;
            4'd6:    v = 5'd30;
            4'd9:    v = 5'd30;
            4'd11:   v = 5'd30;
            default: v = 5'd31;
        endcase
        return v;
    endfunction

    // First day of each month in a year that starts on the first of March
    function automatic logic [8:0] mar_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/dtc_to_secs.sv
module dtc_to_secs (
    input  logic                i_clk,
    input  dtc_pkg::t_in_word   i_in,
    output dtc_pkg::t_out_word  o_res
);

    localparam logic [14:0] RECIP_25  = 15'd20972;   // ceil(2^19 / 25)
    localparam logic [13:0] YEAR_EPOCH = 14'd1997;
    localparam logic [13:0] YEAR_LAST  = 14'd2133;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [7:0]  YO_2100    = 8'd104;     // first offset whose span holds 2100
    localparam logic [16:0] SECS_DAY   = 17'd86400;

    // stage 1
    logic [28:0] n_q25_prod;
    logic [9:0]  r_s1_q25;
    logic [13:0] r_s1_year;
    logic        r_s1_fld_ok;
    logic        r_s1_rng_ok;
    logic [7:0]  r_s1_yo;
    logic [8:0]  r_s1_cum;
    logic [4:0]  r_s1_mlen;
    logic        r_s1_feb;
    logic        r_s1_late;
    logic [4:0]  r_s1_day;
    logic [4:0]  r_s1_hour;
    logic [5:0]  r_s1_min;
    logic [5:0]  r_s1_sec;

    assign n_q25_prod = 29'(i_in.in_year) * 29'(RECIP_25);

    always_ff @(posedge i_clk) begin
        r_s1_q25    <= n_q25_prod[28:19];
        r_s1_year   <= i_in.in_year;
        r_s1_fld_ok <= (i_in.in_year >= 14'd1) && (i_in.in_year <= YEAR_MAX) &&
                       (i_in.in_month >= 4'd1) && (i_in.in_month <= 4'd12) &&
                       (i_in.in_hour <= 5'd23) && (i_in.in_minute <= 6'd59) &&
                       (i_in.in_second <= 6'd59);
        r_s1_rng_ok <= (i_in.in_year >= YEAR_EPOCH) && (i_in.in_year <= YEAR_LAST);
        r_s1_yo     <= 8'(i_in.in_year - YEAR_EPOCH);
        r_s1_cum    <= dtc_pkg::cum_days(i_in.in_month);
        r_s1_mlen   <= dtc_pkg::month_len(i_in.in_month);
        r_s1_feb    <= (i_in.in_month == 4'd2);
        r_s1_late   <= (i_in.in_month > 4'd2);
        r_s1_day    <= i_in.in_day;
        r_s1_hour   <= i_in.in_hour;
        r_s1_min    <= i_in.in_minute;
        r_s1_sec    <= i_in.in_second;
    end

    // stage 2: leap rule, day check, day count without the leap day, time of day
    logic [13:0] n_r25;
    logic        n_leap;
    logic [5:0]  n_mlen;
    logic        n_day_ok;
    logic [16:0] n_days_a;
    logic [16:0] n_hms;
    logic        r_s2_ok;
    logic        r_s2_rng_ok;
    logic [16:0] r_s2_days_a;
    logic        r_s2_lp_add;
    logic [16:0] r_s2_hms;

    assign n_r25    = 14'(r_s1_year - 14'(r_s1_q25) * 14'd25);
    assign n_leap   = (r_s1_year[1:0] == 2'd0) && ((n_r25 != 14'd0) || (r_s1_year[3:0] == 4'd0));
    assign n_mlen   = 6'(r_s1_mlen) + 6'(r_s1_feb && n_leap);
    assign n_day_ok = (r_s1_day != 5'd0) && (6'(r_s1_day) <= n_mlen);
    assign n_days_a = 17'(r_s1_yo) * 17'd365 + 17'(r_s1_yo[7:2]) - 17'(r_s1_yo >= YO_2100) +
                      17'(r_s1_cum) + 17'(r_s1_day) - 17'd1;
    assign n_hms    = 17'(r_s1_hour) * 17'd3600 + 17'(r_s1_min) * 17'd60 + 17'(r_s1_sec);

    always_ff @(posedge i_clk) begin
        r_s2_ok     <= r_s1_fld_ok && n_day_ok;
        r_s2_rng_ok <= r_s1_rng_ok;
        r_s2_days_a <= n_days_a;
        r_s2_lp_add <= n_leap && r_s1_late;
        r_s2_hms    <= n_hms;
    end

    // stage 3: days to seconds
    logic [33:0] r_s3_prod;
    logic        r_s3_ok;
    logic        r_s3_rng_ok;
    logic        r_s3_lp_add;
    logic [16:0] r_s3_hms;

    always_ff @(posedge i_clk) begin
        r_s3_prod   <= 34'(r_s2_days_a) * 34'(SECS_DAY);
        r_s3_ok     <= r_s2_ok;
        r_s3_rng_ok <= r_s2_rng_ok;
        r_s3_lp_add <= r_s2_lp_add;
        r_s3_hms    <= r_s2_hms;
    end

    // stage 4: add the leap day and time of day, flag bad fields, out-of-range years and overflow
    logic [34:0]        n_total;
    logic               n_err;
    dtc_pkg::t_out_word n_s4_res;
    dtc_pkg::t_out_word r_s4_res;
    dtc_pkg::t_out_word r_s5_res;
    dtc_pkg::t_out_word r_s6_res;

    assign n_total = 35'(r_s3_prod) + (r_s3_lp_add ? 35'(SECS_DAY) : 35'd0) + 35'(r_s3_hms);
    assign n_err   = !r_s3_ok || !r_s3_rng_ok || (n_total[34:32] != 3'd0);

    always_comb begin
        n_s4_res            = '0;
        n_s4_res.error_flag = n_err;
        n_s4_res.out_count  = n_err ? 32'd0 : n_total[31:0];
    end

    // stages 5 and 6 hold the word in step with the from-seconds path
    always_ff @(posedge i_clk) begin
        r_s4_res <= n_s4_res;
        r_s5_res <= r_s4_res;
        r_s6_res <= r_s5_res;
    end

    assign o_res = r_s6_res;

endmodule

FILE: rtl/dtc_from_secs.sv
module dtc_from_secs (
    input  logic                i_clk,
    input  logic [31:0]         i_count,
    output dtc_pkg::t_out_word  o_res
);

    localparam logic [25:0] RECIP_675  = 26'd50903317;  // ceil(2^35 / 675)
    localparam logic [13:0] RECIP_225  = 14'd9321;      // ceil(2^21 / 225)
    localparam logic [10:0] RECIP_15   = 11'd1093;      // ceil(2^14 / 15)
    localparam logic [17:0] RECIP_1461 = 18'd183735;    // ceil(2^28 / 1461)
    // Day index of the epoch counted from 1900-03-01
    localparam logic [16:0] DAY_BASE   = 17'd35370;
    // Day index of 2100-03-01; from there on, skip the missing 29 February
    localparam logic [16:0] DAY_2100   = 17'd73049;
    localparam logic [11:0] YEAR_BASE  = 12'd1900;

    // stage 1: day number; count / 86400 = (count / 128) / 675
    logic [50:0] n_day_prod;
    logic [31:0] r_s1_cnt;
    logic [15:0] r_s1_day;

    assign n_day_prod = 51'(i_count[31:7]) * 51'(RECIP_675);

    always_ff @(posedge i_clk) begin
        r_s1_cnt <= i_count;
        r_s1_day <= n_day_prod[50:35];
    end

    // stage 2: second of day, day index on a calendar of plain four-year blocks
    logic [31:0] n_day_secs;
    logic [16:0] n_sod;
    logic [16:0] n_doe;
    logic [16:0] n_doe_adj;
    logic [16:0] r_s2_sod;
    logic [16:0] r_s2_doe;

    assign n_day_secs = 32'(r_s1_day) * 32'd86400;
    assign n_sod      = 17'(r_s1_cnt - n_day_secs);
    assign n_doe      = 17'(r_s1_day) + DAY_BASE;
    assign n_doe_adj  = n_doe + 17'(n_doe >= DAY_2100);

    always_ff @(posedge i_clk) begin
        r_s2_sod <= n_sod;
        r_s2_doe <= n_doe_adj;
    end

    // stage 3: hour, four-year block
    logic [26:0] n_hour_prod;
    logic [34:0] n_blk_prod;
    logic [16:0] r_s3_sod;
    logic [4:0]  r_s3_hour;
    logic [16:0] r_s3_doe;
    logic [5:0]  r_s3_blk;

    assign n_hour_prod = 27'(r_s2_sod[16:4]) * 27'(RECIP_225);
    assign n_blk_prod  = 35'(r_s2_doe) * 35'(RECIP_1461);

    always_ff @(posedge i_clk) begin
        r_s3_sod  <= r_s2_sod;
        r_s3_hour <= n_hour_prod[25:21];
        r_s3_doe  <= r_s2_doe;
        r_s3_blk  <= n_blk_prod[33:28];
    end

    // stage 4: remainders
    logic [11:0] r_s4_rem;
    logic [4:0]  r_s4_hour;
    logic [10:0] r_s4_dob;
    logic [5:0]  r_s4_blk;

    always_ff @(posedge i_clk) begin
        r_s4_rem  <= 12'(r_s3_sod - 17'(r_s3_hour) * 17'd3600);
        r_s4_hour <= r_s3_hour;
        r_s4_dob  <= 11'(r_s3_doe - 17'(r_s3_blk) * 17'd1461);
        r_s4_blk  <= r_s3_blk;
    end

    // stage 5: minute, year within the block, day of year
    logic [19:0] n_min_prod;
    logic [1:0]  n_yob;
    logic [11:0] r_s5_rem;
    logic [4:0]  r_s5_hour;
    logic [5:0]  r_s5_min;
    logic [8:0]  r_s5_doy;
    logic [1:0]  r_s5_yob;
    logic [5:0]  r_s5_blk;

    assign n_min_prod = 20'(r_s4_rem[11:2]) * 20'(RECIP_15);

    always_comb begin
        n_yob = 2'd0;
        if (r_s4_dob >= 11'd365) begin
            n_yob = 2'd1;
        end
        if (r_s4_dob >= 11'd730) begin
            n_yob = 2'd2;
        end
        if (r_s4_dob >= 11'd1095) begin
            n_yob = 2'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_rem  <= r_s4_rem;
        r_s5_hour <= r_s4_hour;
        r_s5_min  <= n_min_prod[19:14];
        r_s5_doy  <= 9'(r_s4_dob - 11'(n_yob) * 11'd365);
        r_s5_yob  <= n_yob;
        r_s5_blk  <= r_s4_blk;
    end

    // stage 6: second, month and day, calendar year
    logic [3:0]         n_mp;
    logic [3:0]         n_month;
    logic [4:0]         n_mday;
    logic [11:0]        n_year;
    dtc_pkg::t_out_word n_s6_res;
    dtc_pkg::t_out_word r_s6_res;

    always_comb begin
        n_mp = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (r_s5_doy >= dtc_pkg::mar_start(4'(k))) begin
                n_mp = 4'(k);
            end
        end
    end

    assign n_month = (n_mp < 4'd10) ? n_mp + 4'd3 : n_mp - 4'd9;
    assign n_mday  = 5'(r_s5_doy - dtc_pkg::mar_start(n_mp) + 9'd1);
    assign n_year  = YEAR_BASE + {4'd0, r_s5_blk, 2'b00} + 12'(r_s5_yob) +
                     12'(n_month <= 4'd2);

    always_comb begin
        n_s6_res            = '0;
        n_s6_res.out_year   = n_year;
        n_s6_res.out_month  = n_month;
        n_s6_res.out_day    = n_mday;
        n_s6_res.out_hour   = r_s5_hour;
        n_s6_res.out_minute = r_s5_min;
        n_s6_res.out_second = 6'(r_s5_rem - 12'(r_s5_min) * 12'd60);
    end

    always_ff @(posedge i_clk) begin
        r_s6_res <= n_s6_res;
    end

    assign o_res = r_s6_res;

endmodule

FILE: rtl/datetime_epoch_seconds_converter.sv
// Port      Dir  Payload      Handshake
// i_in      in   t_in_word    taken when start is high and busy is low
// o_out     out  t_out_word   shown for one cycle while o_valid is high
//
// One word may be taken every cycle; its result passes through the six-stage
// conversion paths and then the output register.
// Both directions run side by side and the output register picks by func.
// Reset is synchronous, active low; busy is high only while it is held.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module datetime_epoch_seconds_converter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  dtc_pkg::t_in_word  i_in,
    output logic               busy,
    output logic               o_valid,
    output dtc_pkg::t_out_word o_out
);

    localparam int LAT = dtc_pkg::DTC_LAT;

    logic               n_acc;
    logic [LAT-1:0]     r_vld;
    logic [LAT-1:0]     r_fn;
    logic               r_valid;
    dtc_pkg::t_out_word r_out;
    dtc_pkg::t_out_word n_to_res;
    dtc_pkg::t_out_word n_from_res;

    assign busy  = !i_rst_n;
    assign n_acc = start && !busy;

    dtc_to_secs u_to_secs (
        .i_clk (i_clk),
        .i_in  (i_in),
        .o_res (n_to_res)
    );

    dtc_from_secs u_from_secs (
        .i_clk   (i_clk),
        .i_count (i_in.in_count),
        .o_res   (n_from_res)
    );

    // valid bits and direction travel alongside the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[LAT-2:0], n_acc};
            r_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_fn  <= {r_fn[LAT-2:0], i_in.func};
        r_out <= (r_fn[LAT-1] == dtc_pkg::FUNC_FROM_SECS) ? n_from_res : n_to_res;
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_acc |-> ##(LAT + 1) o_valid)
        else $error("accepted word produced no result");

    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(n_acc, LAT + 1))
        else $error("result without an accepted word");

    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.error_flag) |-> (o_out.out_count == 32'd0))
        else $error("error result carries a count");

    a_mode_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out.out_count != 32'd0)) |->
        ((o_out.out_year == 12'd0) && (o_out.out_month == 4'd0)))
        else $error("count and date both set");

    a_date_sane : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out.out_year != 12'd0)) |->
        ((o_out.out_month >= 4'd1) && (o_out.out_month <= 4'd12) &&
         (o_out.out_hour <= 5'd23) && (o_out.out_minute <= 6'd59) &&
         (o_out.out_second <= 6'd59) && (o_out.out_day != 5'd0)))
        else $error("date result out of range");

endmodule
